// ===== design/threshold_centroid_finder_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef THRESHOLD_CENTROID_FINDER_DEFINES_SVH
`define THRESHOLD_CENTROID_FINDER_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define TCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("centroid finder check failed");

// Next-cycle implication, quiet while reset is asserted.
`define TCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("centroid finder check failed");

`endif

// ===== design/tcf_pkg.sv =====
package tcf_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 33;
    localparam int TALLY_W = 23;
    localparam int COORD_W = 15;

    localparam logic [PIX_W-1:0]   THRESHOLD_RESET = 8'd130;
    localparam logic [SUM_W-1:0]   SUM_MAX         = '1;
    localparam logic [TALLY_W-1:0] TALLY_MAX       = '1;
    localparam logic [COORD_W-1:0] COORD_MAX       = '1;

    // Frame totals handed from the front end to the divider.
    typedef struct packed {
        logic [SUM_W-1:0]   column_sum;
        logic [SUM_W-1:0]   row_sum;
        logic [TALLY_W-1:0] tally;
    } frame_totals_t;

endpackage

// ===== design/tcf_pixel_if.sv =====
interface tcf_pixel_if;
    logic                     valid;
    logic                     ready;
    logic [tcf_pkg::PIX_W-1:0] pixel;
    logic                     end_of_line;
    logic                     end_of_frame;

    modport source (output valid, output pixel, output end_of_line, output end_of_frame,
                    input ready);
    modport sink   (input valid, input pixel, input end_of_line, input end_of_frame,
                    output ready);
endinterface

// ===== design/tcf_result_if.sv =====
interface tcf_result_if;
    logic                         valid;
    logic                         ready;
    logic [tcf_pkg::COORD_W-1:0]  centroid_x;
    logic [tcf_pkg::COORD_W-1:0]  centroid_y;
    logic [tcf_pkg::TALLY_W-1:0]  bright_count;
    logic                         found;

    modport source (output valid, output centroid_x, output centroid_y,
                    output bright_count, output found, input ready);
    modport sink   (input valid, input centroid_x, input centroid_y,
                    input bright_count, input found, output ready);
endinterface

// ===== design/tcf_front.sv =====
module tcf_front #(
    parameter int MAX_COLUMNS = 2048,
    parameter int MAX_ROWS    = 2048
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcf_pkg::PIX_W-1:0]   cfg_wdata,
    tcf_pixel_if.sink                   pix,
    input  logic                        q_full,
    output logic                        q_push,
    output tcf_pkg::frame_totals_t      q_data
);
    import tcf_pkg::*;

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);

    logic [PIX_W-1:0]   thresh_reg;
    logic [COL_W-1:0]   col_idx_reg;
    logic [ROW_W-1:0]   row_idx_reg;
    logic [SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [SUM_W-1:0]   row_sum_reg, row_sum_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [SUM_W:0]     col_add, row_add;
    logic               accept;
    logic               bright;

    assign pix.ready = !q_full;
    assign accept    = pix.valid && pix.ready;
    assign bright    = pix.pixel > thresh_reg;

    assign col_add = {1'b0, col_sum_reg} + (SUM_W+1)'(col_idx_reg);
    assign row_add = {1'b0, row_sum_reg} + (SUM_W+1)'(row_idx_reg);

    // Count the current pixel before the frame totals leave.
    always_comb
    begin
        col_sum_next = col_sum_reg;
        row_sum_next = row_sum_reg;
        tally_next   = tally_reg;
        if (bright)
        begin
            col_sum_next = col_add[SUM_W] ? SUM_MAX : col_add[SUM_W-1:0];
            row_sum_next = row_add[SUM_W] ? SUM_MAX : row_add[SUM_W-1:0];
            if (tally_reg != TALLY_MAX)
                tally_next = tally_reg + 1'b1;
        end
    end

    assign q_push            = accept && pix.end_of_frame;
    assign q_data.column_sum = col_sum_next;
    assign q_data.row_sum    = row_sum_next;
    assign q_data.tally      = tally_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thresh_reg <= THRESHOLD_RESET;
        else if (cfg_we)
            thresh_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg <= '0;
            row_idx_reg <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            tally_reg   <= '0;
        end
        else if (accept)
        begin
            if (pix.end_of_frame)
            begin
                col_idx_reg <= '0;
                row_idx_reg <= '0;
                col_sum_reg <= '0;
                row_sum_reg <= '0;
                tally_reg   <= '0;
            end
            else
            begin
                col_sum_reg <= col_sum_next;
                row_sum_reg <= row_sum_next;
                tally_reg   <= tally_next;
                if (pix.end_of_line)
                begin
                    col_idx_reg <= '0;
                    if (row_idx_reg < ROW_LAST)
                        row_idx_reg <= row_idx_reg + 1'b1;
                end
                else if (col_idx_reg < COL_LAST)
                begin
                    col_idx_reg <= col_idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ===== design/tcf_queue.sv =====
module tcf_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  tcf_pkg::frame_totals_t  push_data,
    input  logic                    pop,
    output tcf_pkg::frame_totals_t  pop_data,
    output logic                    full,
    output logic                    empty
);
    import tcf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    frame_totals_t      slots[DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full     = count_reg == (PTR_W+1)'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/tcf_divider.sv =====
module tcf_divider #(
    parameter int FRACTION_BITS = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  tcf_pkg::frame_totals_t  q_data,
    output logic                    q_pop,
    tcf_result_if.source            res
);
    import tcf_pkg::*;

    localparam int DIVD_W = SUM_W + FRACTION_BITS;
    localparam int STEPS  = DIVD_W;
    localparam int CNT_W  = $clog2(STEPS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    step_reg;
    logic [DIVD_W-1:0]   divd_x_reg, divd_y_reg;
    logic [DIVD_W-1:0]   quo_x_reg, quo_y_reg;
    logic [TALLY_W-1:0]  rem_x_reg, rem_y_reg;
    logic [TALLY_W-1:0]  tally_reg;
    logic [TALLY_W:0]    trial_x, trial_y;
    logic                ge_x, ge_y;
    logic [COORD_W-1:0]  sat_x, sat_y;
    logic                out_valid_reg;
    logic [COORD_W-1:0]  cx_reg, cy_reg;
    logic [TALLY_W-1:0]  cnt_reg;
    logic                found_reg;
    logic                load_out;

    // One quotient bit per cycle for both axes.
    assign trial_x = {rem_x_reg, divd_x_reg[DIVD_W-1]};
    assign trial_y = {rem_y_reg, divd_y_reg[DIVD_W-1]};
    assign ge_x    = trial_x >= {1'b0, tally_reg};
    assign ge_y    = trial_y >= {1'b0, tally_reg};

    assign sat_x = (|quo_x_reg[DIVD_W-1:COORD_W]) ? COORD_MAX : quo_x_reg[COORD_W-1:0];
    assign sat_y = (|quo_y_reg[DIVD_W-1:COORD_W]) ? COORD_MAX : quo_y_reg[COORD_W-1:0];

    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign load_out = (state_reg == ST_HOLD) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step_reg == CNT_W'(1))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                step_reg <= CNT_W'(STEPS);
            else if (state_reg == ST_RUN)
                step_reg <= step_reg - 1'b1;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            divd_x_reg <= DIVD_W'(q_data.column_sum) << FRACTION_BITS;
            divd_y_reg <= DIVD_W'(q_data.row_sum) << FRACTION_BITS;
            quo_x_reg  <= '0;
            quo_y_reg  <= '0;
            rem_x_reg  <= '0;
            rem_y_reg  <= '0;
            tally_reg  <= q_data.tally;
        end
        else if (state_reg == ST_RUN)
        begin
            divd_x_reg <= divd_x_reg << 1;
            divd_y_reg <= divd_y_reg << 1;
            quo_x_reg  <= {quo_x_reg[DIVD_W-2:0], ge_x};
            quo_y_reg  <= {quo_y_reg[DIVD_W-2:0], ge_y};
            rem_x_reg  <= ge_x ? TALLY_W'(trial_x - {1'b0, tally_reg}) : trial_x[TALLY_W-1:0];
            rem_y_reg  <= ge_y ? TALLY_W'(trial_y - {1'b0, tally_reg}) : trial_y[TALLY_W-1:0];
        end
    end

    // Register the result for the output; an empty frame forces coordinates to zero.
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg <= tally_reg != '0;
            cnt_reg   <= tally_reg;
            cx_reg    <= (tally_reg != '0) ? sat_x : '0;
            cy_reg    <= (tally_reg != '0) ? sat_y : '0;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.centroid_x   = cx_reg;
    assign res.centroid_y   = cy_reg;
    assign res.bright_count = cnt_reg;
    assign res.found        = found_reg;

endmodule

// ===== design/threshold_centroid_finder.sv =====
// Throughput: one pixel beat per cycle; the input stalls only while two finished
// frames wait in the queue ahead of the divider.
// Results: a frame's totals enter the queue on its end-of-frame beat and are then
// divided by the one-bit-per-cycle shared divider.
// Reset: asynchronous, active low; clears indices, sums, queue and output valid,
// and loads the threshold register with 130.
module threshold_centroid_finder #(
    parameter int MAX_COLUMNS   = 2048,
    parameter int MAX_ROWS      = 2048,
    parameter int FRACTION_BITS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcf_pkg::PIX_W-1:0]   cfg_wdata,
    tcf_pixel_if.sink                   pixel_stream,
    tcf_result_if.source                centroid
);
    import tcf_pkg::*;

    frame_totals_t  push_data;
    frame_totals_t  pop_data;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;

    tcf_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pix       (pixel_stream),
        .q_full    (q_full),
        .q_push    (push),
        .q_data    (push_data)
    );

    tcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    tcf_divider #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_divider (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (pop_data),
        .q_pop   (pop),
        .res     (centroid)
    );

endmodule

// ===== design/tcf_checker.sv =====
`include "threshold_centroid_finder_defines.svh"

module tcf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tcf_pkg::COORD_W-1:0]  centroid_x,
    input logic [tcf_pkg::COORD_W-1:0]  centroid_y,
    input logic [tcf_pkg::TALLY_W-1:0]  bright_count,
    input logic                         found
);
    import tcf_pkg::*;

    logic [2*COORD_W+TALLY_W:0] beat_bits;

    assign beat_bits = {centroid_x, centroid_y, bright_count, found};

    `TCF_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)
    `TCF_ASSERT_NEXT(a_hold_beat, clk, rst_n, out_valid && !out_ready, $stable(beat_bits))
    `TCF_ASSERT_NOW(a_found_count, clk, rst_n, out_valid, found == (bright_count != '0))
    `TCF_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && !found, (centroid_x | centroid_y) == '0)

endmodule

bind threshold_centroid_finder tcf_checker u_tcf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (centroid.valid),
    .out_ready    (centroid.ready),
    .centroid_x   (centroid.centroid_x),
    .centroid_y   (centroid.centroid_y),
    .bright_count (centroid.bright_count),
    .found        (centroid.found)
);

// ===== test/threshold_centroid_finder_test.sv =====
`timescale 1ns / 1ps

module threshold_centroid_finder_test;
    import tcf_pkg::*;

    localparam int INDEX_W   = 11;
    localparam int FRAC_BITS = 4;
    localparam logic [INDEX_W-1:0] LAST_COLUMN = INDEX_W'(2047);
    localparam logic [INDEX_W-1:0] LAST_ROW    = INDEX_W'(2047);

    localparam int SETTLE_CYCLES      = 64;
    localparam int LONG_HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASE_BEATS = 180;
    localparam int QUIET_PHASE_BEATS  = 130;
    localparam int BURST_FRAMES       = 30;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TALLY_W-1:0] count;
        logic               found;
    } centroid_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             eol;
        logic             eof;
        logic             typed;
        centroid_t        want;
    } directed_row_t;

    localparam centroid_t UNTYPED    = '0;
    localparam centroid_t EMPTY      = '0;
    localparam centroid_t ORIGIN_ONE = '{15'd0, 15'd0, 23'd1, 1'b1};

    // Threshold is at its reset value while this table runs.
    localparam int DIRECTED_LEN = 22;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{8'd255, 1'b0, 1'b1, 1'b1, ORIGIN_ONE},  // full-scale lone pixel
        '{8'd0,   1'b0, 1'b1, 1'b1, EMPTY},       // black frame
        '{8'd130, 1'b0, 1'b1, 1'b1, EMPTY},       // equal to threshold is dark
        '{8'd131, 1'b0, 1'b1, 1'b1, ORIGIN_ONE},
        '{8'd0,   1'b0, 1'b0, 1'b0, UNTYPED},     // 3x3 frame
        '{8'd200, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd10,  1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'd255, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd255, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd0,   1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'd0,   1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd0,   1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd180, 1'b0, 1'b1, 1'b0, UNTYPED},
        '{8'd255, 1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'd0,   1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd255, 1'b1, 1'b1, 1'b0, UNTYPED},     // line and frame end together
        '{8'd200, 1'b0, 1'b1, 1'b1, ORIGIN_ONE},  // indices must be back at origin
        '{8'd255, 1'b1, 1'b0, 1'b0, UNTYPED},     // one-pixel rows
        '{8'd255, 1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'd255, 1'b0, 1'b1, 1'b0, UNTYPED},
        '{8'd129, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'd254, 1'b0, 1'b1, 1'b0, UNTYPED}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [PIX_W-1:0] cfg_wdata;

    tcf_pixel_if  pixel_bus ();
    tcf_result_if centroid_bus ();

    threshold_centroid_finder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .pixel_stream (pixel_bus),
        .centroid     (centroid_bus)
    );

    // Frame accumulator mirror
    logic [PIX_W-1:0]   threshold_q;
    logic [INDEX_W-1:0] col_idx;
    logic [INDEX_W-1:0] row_idx;
    logic [SUM_W-1:0]   col_acc;
    logic [SUM_W-1:0]   row_acc;
    logic [TALLY_W-1:0] tally;

    centroid_t pending_centroids[$];
    int        error_count;
    int        beats_sent;
    bit        quiet_tail;
    bit        long_hold_due;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void clear_frame();
        col_idx = '0;
        row_idx = '0;
        col_acc = '0;
        row_acc = '0;
        tally   = '0;
    endfunction

    function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc,
                                                 logic [INDEX_W-1:0] idx);
        logic [SUM_W:0] total;
        total = {1'b0, acc} + (SUM_W+1)'(idx);
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

    function automatic logic [COORD_W-1:0] mean_coord(logic [SUM_W-1:0] acc,
                                                      logic [TALLY_W-1:0] n);
        logic [63:0] q;
        if (n == '0)
        begin
            return '0;
        end
        q = (64'(acc) << FRAC_BITS) / 64'(n);
        return (q > 64'(COORD_MAX)) ? COORD_MAX : q[COORD_W-1:0];
    endfunction

    function automatic bit account_pixel(logic [PIX_W-1:0] pix, logic eol, logic eof,
                                         output centroid_t res);
        res = '0;
        if (pix > threshold_q)
        begin
            col_acc = sum_sat(col_acc, col_idx);
            row_acc = sum_sat(row_acc, row_idx);
            if (tally != TALLY_MAX)
            begin
                tally = tally + 1'b1;
            end
        end
        // the current pixel is already counted when the frame closes
        if (eof)
        begin
            res.x     = mean_coord(col_acc, tally);
            res.y     = mean_coord(row_acc, tally);
            res.count = tally;
            res.found = (tally != '0);
            clear_frame();
            return 1'b1;
        end
        if (eol)
        begin
            col_idx = '0;
            if (row_idx != LAST_ROW)
            begin
                row_idx = row_idx + 1'b1;
            end
        end
        else if (col_idx != LAST_COLUMN)
        begin
            col_idx = col_idx + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int roll;
        int level;
        roll = $urandom_range(0, 99);
        if (roll < 10)
        begin
            return '0;
        end
        if (roll < 20)
        begin
            return '1;
        end
        if (roll < 40)
        begin
            // straddle the threshold
            level = int'(threshold_q) + int'($urandom_range(0, 2)) - 1;
            level = (level < 0) ? 0 : ((level > 255) ? 255 : level);
            return PIX_W'(level);
        end
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_centroid();
        centroid_t want;
        if (pending_centroids.size() == 0)
        begin
            $error("centroid beat with no frame outstanding");
            error_count++;
            return;
        end
        want = pending_centroids.pop_front();
        compare_field("centroid_x", 32'(want.x), 32'(centroid_bus.centroid_x));
        compare_field("centroid_y", 32'(want.y), 32'(centroid_bus.centroid_y));
        compare_field("bright_count", 32'(want.count), 32'(centroid_bus.bright_count));
        compare_field("found", 32'(want.found), 32'(centroid_bus.found));
    endfunction

    task automatic send_beat(input logic [PIX_W-1:0] pix, input logic eol, input logic eof,
                             input bit typed = 1'b0, input centroid_t want = '0);
        centroid_t res;
        bit        emitted;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            pixel_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        pixel_bus.valid        <= 1'b1;
        pixel_bus.pixel        <= pix;
        pixel_bus.end_of_line  <= eol;
        pixel_bus.end_of_frame <= eof;
        do
            @(posedge clk);
        while (!pixel_bus.ready);
        emitted = account_pixel(pix, eol, eof, res);
        if (emitted)
        begin
            pending_centroids.push_back(typed ? want : res);
        end
        beats_sent++;
    endtask

    // Drop valid, drain every outstanding centroid, then let the divider go quiet.
    task automatic settle();
        pixel_bus.valid <= 1'b0;
        while (pending_centroids.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [PIX_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        threshold_q = value;
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_frame();
        int  style;
        int  width;
        int  height;
        int  n;
        int  i;
        int  r;
        int  c;
        bit  last_row;
        bit  last_col;
        style = $urandom_range(0, 9);
        if (style == 0)
        begin
            // noise: marks land anywhere, frame may close early
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++)
            begin
                send_beat(pick_pixel(), $urandom_range(0, 3) == 0,
                          i == n - 1 || $urandom_range(0, 15) == 0);
            end
        end
        else
        begin
            height = $urandom_range(1, 6);
            width  = $urandom_range(1, 12);
            for (r = 0; r < height; r++)
            begin
                // ragged rows on one style
                if (style == 1)
                begin
                    width = $urandom_range(1, 12);
                end
                for (c = 0; c < width; c++)
                begin
                    last_row = (r == height - 1);
                    last_col = (c == width - 1);
                    send_beat(pick_pixel(),
                              last_col && (!last_row || $urandom_range(0, 1) == 1),
                              last_row && last_col);
                end
            end
        end
    endtask

    initial
    begin
        int                 target;
        int                 i;
        logic [PIX_W-1:0]   phase_thresholds [5];
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_wdata              <= '0;
        pixel_bus.valid        <= 1'b0;
        pixel_bus.pixel        <= '0;
        pixel_bus.end_of_line  <= 1'b0;
        pixel_bus.end_of_frame <= 1'b0;
        error_count   = 0;
        beats_sent    = 0;
        quiet_tail    = 1'b0;
        long_hold_due = 1'b0;
        threshold_q   = THRESHOLD_RESET;
        clear_frame();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIRECTED_LEN; i++)
        begin
            send_beat(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].eol, DIRECTED_ROWS[i].eof,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        settle();

        phase_thresholds[0] = 8'd0;
        phase_thresholds[1] = 8'd255;
        for (i = 2; i < 5; i++)
        begin
            phase_thresholds[i] = PIX_W'($urandom_range(1, 254));
        end
        for (i = 0; i < 5; i++)
        begin
            write_threshold(phase_thresholds[i]);
            target = beats_sent + RANDOM_PHASE_BEATS;
            while (beats_sent < target)
            begin
                send_random_frame();
            end
            settle();
        end

        // hold the result side off while one-pixel frames pile up
        long_hold_due = 1'b1;
        for (i = 0; i < BURST_FRAMES; i++)
        begin
            send_beat(pick_pixel(), $urandom_range(0, 1) == 1, 1'b1);
        end
        settle();

        quiet_tail = 1'b1;
        write_threshold(PIX_W'($urandom_range(0, 255)));
        target = beats_sent + QUIET_PHASE_BEATS;
        while (beats_sent < target)
        begin
            send_random_frame();
        end
        settle();

        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        centroid_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (centroid_bus.valid && centroid_bus.ready)
            begin
                check_centroid();
            end
            if (stall_left > 0)
            begin
                stall_left--;
                centroid_bus.ready <= 1'b0;
            end
            else if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                stall_left    = LONG_HOLD_CYCLES - 1;
                centroid_bus.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 9);
                centroid_bus.ready <= 1'b0;
            end
            else
            begin
                centroid_bus.ready <= 1'b1;
            end
        end
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/tcf_pkg.sv
design/tcf_pixel_if.sv
design/tcf_result_if.sv
design/tcf_front.sv
design/tcf_queue.sv
design/tcf_divider.sv
design/threshold_centroid_finder.sv
design/tcf_checker.sv
test/threshold_centroid_finder_test.sv
